FILE: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants for the Playfair digraph cipher core
// Opcodes, letter codes, table write bundle and the ASCII letter folding.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int unsigned Cells   = 25;
  localparam int unsigned Letters = 26;

  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterX = 5'd23;

  localparam logic [7:0] AsciiLowA = 8'h61;
  localparam logic [7:0] AsciiLowZ = 8'h7a;
  localparam logic [7:0] AsciiUpA  = 8'h41;
  localparam logic [7:0] AsciiUpZ  = 8'h5a;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_KEY_CHAR   = 3'd1,
    OP_KEY_FINISH = 3'd2,
    OP_TEXT_CHAR  = 3'd3,
    OP_TEXT_END   = 3'd4
  } op_t;

  // one write into both key tables: square[slot] = letter, position[letter] = slot
  typedef struct packed {
    logic       en;
    logic [4:0] slot;
    logic [4:0] letter;
  } pfc_wr_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } pfc_fold_t;

  // letter index 0..25 with j folded onto i; ok is low for non-letters
  function automatic pfc_fold_t fold_letter(input logic [7:0] c);
    pfc_fold_t r;
    r.ok  = 1'b0;
    r.idx = '0;
    if (c >= AsciiLowA && c <= AsciiLowZ) begin
      r.ok  = 1'b1;
      r.idx = 5'(c - AsciiLowA);
    end else if (c >= AsciiUpA && c <= AsciiUpZ) begin
      r.ok  = 1'b1;
      r.idx = 5'(c - AsciiUpA);
    end
    if (r.idx == LetterJ) begin
      r.idx = LetterI;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/playfair_digraph_cipher_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core: Playfair key loader and digraph cipher
// Builds the 5x5 key square, pairs text letters and ciphers each digraph.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_stall    | in_opcode, in_char_in
//   out     | out_valid / out_stall  | out_first_letter, out_second_letter,
//           |                        | out_has_pair, out_last
//   cfg     | cfg_valid / cfg_ready  | cfg_decrypt_mode
//
// clear_key, key_char and text_char without a result finish in IDLE; key_finish
// walks the alphabet in FILL, one alphabet letter per cycle into the key tables.
// A digraph runs POS_A, POS_B, RULE, SQ_B, EMIT: two position reads, rule unit,
// two square reads. A result waits in the output register while out_stall is
// high; the block stays stalled only if a new result is ready.
// Reset clears the key state and pending letter; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_opcode,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_first_letter,
  output logic      [7:0] out_second_letter,
  output logic            out_has_pair,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_decrypt_mode
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_POS_A = 7'b0000100,
    S_POS_B = 7'b0001000,
    S_RULE  = 7'b0010000,
    S_SQ_B  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  walk_r, walk_nxt;
  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        key_ready_r, key_ready_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [4:0]  pend_letter_r, pend_letter_nxt;
  logic [4:0]  a_r, a_nxt;
  logic [4:0]  b_r, b_nxt;
  logic        last_r, last_nxt;
  logic        pair_r, pair_nxt;
  logic [4:0]  pa_r, pa_nxt;
  logic [4:0]  cell2_r, cell2_nxt;
  logic [4:0]  o1_r, o1_nxt;
  logic        decrypt_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_first_r, out_first_nxt;
  logic [7:0]  out_second_r, out_second_nxt;
  logic        out_pair_r, out_pair_nxt;
  logic        out_last_r, out_last_nxt;

  pfc_pkg::pfc_wr_t  wr;
  pfc_pkg::pfc_fold_t in_fold;
  logic        in_acc;
  logic [4:0]  place_idx;
  logic        place_ok;
  logic        sq_rd_en, pos_rd_en;
  logic [4:0]  sq_rd_addr, pos_rd_addr;
  logic [4:0]  sq_rdata, pos_rdata;
  logic [4:0]  rule_cell_a, rule_cell_b;

  pfc_store u_store (
    .clk         (clk),
    .wr          (wr),
    .sq_rd_en    (sq_rd_en),
    .sq_rd_addr  (sq_rd_addr),
    .sq_rdata    (sq_rdata),
    .pos_rd_en   (pos_rd_en),
    .pos_rd_addr (pos_rd_addr),
    .pos_rdata   (pos_rdata)
  );

  pfc_rule_unit u_rule (
    .decrypt (decrypt_r),
    .pos_a   (pa_r),
    .pos_b   (pos_rdata),
    .cell_a  (rule_cell_a),
    .cell_b  (rule_cell_b)
  );

  assign in_fold   = pfc_pkg::fold_letter(in_char_in);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign place_idx = (state_r == S_FILL) ? walk_r : in_fold.idx;
  assign place_ok  = !used_r[place_idx] && (fill_r < 5'(pfc_pkg::Cells));

  always_comb begin
    state_nxt       = state_r;
    walk_nxt        = walk_r;
    used_nxt        = used_r;
    fill_nxt        = fill_r;
    key_ready_nxt   = key_ready_r;
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    last_nxt        = last_r;
    pair_nxt        = pair_r;
    pa_nxt          = pa_r;
    cell2_nxt       = cell2_r;
    o1_nxt          = o1_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_pair_nxt    = out_pair_r;
    out_last_nxt    = out_last_r;
    wr              = '0;
    sq_rd_en        = 1'b0;
    sq_rd_addr      = cell2_r;
    pos_rd_en       = 1'b0;
    pos_rd_addr     = a_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            pfc_pkg::OP_CLEAR: begin
              used_nxt        = '0;
              fill_nxt        = '0;
              key_ready_nxt   = 1'b0;
              pend_valid_nxt  = 1'b0;
              pend_letter_nxt = '0;
            end
            pfc_pkg::OP_KEY_CHAR: begin
              if (!key_ready_r && in_fold.ok && place_ok) begin
                wr.en                = 1'b1;
                wr.slot              = fill_r;
                wr.letter            = place_idx;
                used_nxt[place_idx]  = 1'b1;
                fill_nxt             = 5'(fill_r + 5'd1);
              end
            end
            pfc_pkg::OP_KEY_FINISH: begin
              if (!key_ready_r) begin
                walk_nxt  = '0;
                state_nxt = S_FILL;
              end
            end
            pfc_pkg::OP_TEXT_CHAR: begin
              if (key_ready_r && in_fold.ok) begin
                if (!pend_valid_r) begin
                  pend_valid_nxt  = 1'b1;
                  pend_letter_nxt = in_fold.idx;
                end else begin
                  a_nxt     = pend_letter_r;
                  last_nxt  = 1'b0;
                  pair_nxt  = 1'b1;
                  state_nxt = S_POS_A;
                  if (in_fold.idx == pend_letter_r) begin
                    // doubled letter: cipher with filler, letter stays pending
                    b_nxt = pfc_pkg::LetterX;
                  end else begin
                    b_nxt           = in_fold.idx;
                    pend_valid_nxt  = 1'b0;
                    pend_letter_nxt = '0;
                  end
                end
              end
            end
            pfc_pkg::OP_TEXT_END: begin
              if (key_ready_r) begin
                last_nxt        = 1'b1;
                pend_valid_nxt  = 1'b0;
                pend_letter_nxt = '0;
                a_nxt           = pend_letter_r;
                b_nxt           = pfc_pkg::LetterX;
                pair_nxt        = pend_valid_r;
                state_nxt       = pend_valid_r ? S_POS_A : S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if ((walk_r != pfc_pkg::LetterJ) && place_ok) begin
          wr.en               = 1'b1;
          wr.slot             = fill_r;
          wr.letter           = place_idx;
          used_nxt[place_idx] = 1'b1;
          fill_nxt            = 5'(fill_r + 5'd1);
        end
        if (walk_r == 5'(pfc_pkg::Letters - 1)) begin
          key_ready_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          walk_nxt = 5'(walk_r + 5'd1);
        end
      end
      S_POS_A: begin
        pos_rd_en   = 1'b1;
        pos_rd_addr = a_r;
        state_nxt   = S_POS_B;
      end
      S_POS_B: begin
        pos_rd_en   = 1'b1;
        pos_rd_addr = b_r;
        pa_nxt      = pos_rdata;
        state_nxt   = S_RULE;
      end
      S_RULE: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = rule_cell_a;
        cell2_nxt  = rule_cell_b;
        state_nxt  = S_SQ_B;
      end
      S_SQ_B: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = cell2_r;
        o1_nxt     = sq_rdata;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = pair_r ? 8'(pfc_pkg::AsciiLowA + 8'(o1_r)) : '0;
          out_second_nxt = pair_r ? 8'(pfc_pkg::AsciiLowA + 8'(sq_rdata)) : '0;
          out_pair_nxt   = pair_r;
          out_last_nxt   = last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      walk_r        <= '0;
      used_r        <= '0;
      fill_r        <= '0;
      key_ready_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      out_valid_r   <= 1'b0;
      decrypt_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      walk_r        <= walk_nxt;
      used_r        <= used_nxt;
      fill_r        <= fill_nxt;
      key_ready_r   <= key_ready_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        decrypt_r <= cfg_decrypt_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    last_r       <= last_nxt;
    pair_r       <= pair_nxt;
    pa_r         <= pa_nxt;
    cell2_r      <= cell2_nxt;
    o1_r         <= o1_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_pair_r   <= out_pair_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_first_letter  = out_first_r;
  assign out_second_letter = out_second_r;
  assign out_has_pair      = out_pair_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/pfc_store.sv
// ----------------------------------------------------------------------------
// pfc_store: key square and letter position tables
// One shared write port fills both tables; each has one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_store (
  input  wire logic            clk,
  input  wire pfc_pkg::pfc_wr_t wr,
  input  wire logic            sq_rd_en,
  input  wire logic [4:0]      sq_rd_addr,
  output logic      [4:0]      sq_rdata,
  input  wire logic            pos_rd_en,
  input  wire logic [4:0]      pos_rd_addr,
  output logic      [4:0]      pos_rdata
);

  logic [4:0] sq_mem  [pfc_pkg::Cells];
  logic [4:0] pos_mem [pfc_pkg::Letters];
  logic [4:0] sq_rdata_r;
  logic [4:0] pos_rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      sq_mem[wr.slot]    <= wr.letter;
      pos_mem[wr.letter] <= wr.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rd_en) begin
      sq_rdata_r <= sq_mem[sq_rd_addr];
    end
    if (pos_rd_en) begin
      pos_rdata_r <= pos_mem[pos_rd_addr];
    end
  end

  assign sq_rdata  = sq_rdata_r;
  assign pos_rdata = pos_rdata_r;

endmodule

`default_nettype wire

FILE: rtl/pfc_rule_unit.sv
// ----------------------------------------------------------------------------
// pfc_rule_unit: Playfair digraph rule evaluation
// Splits two cell positions into row/column, applies the same-row,
// same-column or rectangle rule and returns the two output cells.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_rule_unit (
  input  wire logic       decrypt,
  input  wire logic [4:0] pos_a,
  input  wire logic [4:0] pos_b,
  output logic      [4:0] cell_a,
  output logic      [4:0] cell_b
);

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] step5(input logic [2:0] x, input logic dec);
    logic [2:0] y;
    if (dec) begin
      y = (x == 3'd0) ? 3'd4 : 3'(x - 3'd1);
    end else begin
      y = (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
    end
    return y;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

  logic [2:0] row_a, row_b, col_a, col_b;

  always_comb begin
    row_a = row_of(pos_a);
    row_b = row_of(pos_b);
    col_a = 3'(pos_a - cell_of(row_a, 3'd0));
    col_b = 3'(pos_b - cell_of(row_b, 3'd0));
    priority if (row_a == row_b) begin
      cell_a = cell_of(row_a, step5(col_a, decrypt));
      cell_b = cell_of(row_b, step5(col_b, decrypt));
    end else if (col_a == col_b) begin
      cell_a = cell_of(step5(row_a, decrypt), col_a);
      cell_b = cell_of(step5(row_b, decrypt), col_b);
    end else begin
      cell_a = cell_of(row_a, col_b);
      cell_b = cell_of(row_b, col_a);
    end
  end

endmodule

`default_nettype wire
